@@ src/imh_pkg.sv @@
// ----------------------------------------------------------------------------
// imh_pkg: invariant mass histogram shared definitions
// Field widths, histogram geometry and configuration register indexes.
// ----------------------------------------------------------------------------
package imh_pkg;

  // histogram geometry
  localparam int NUM_BINS   = 200;
  localparam int SLOT_TOTAL = NUM_BINS + 2;
  localparam int SLOT_W     = 8;

  // payload widths
  localparam int E_W      = 21;
  localparam int P_W      = 22;
  localparam int MASS_W   = 22;
  localparam int COUNT_W  = 32;
  localparam int CFG_W    = 22;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_EDGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 1'b1;

  localparam logic [CFG_W-1:0] BIN_WIDTH_RST = 22'd30;

  // opcodes
  localparam logic OP_FILL = 1'b0;
  localparam logic OP_READ = 1'b1;

endpackage

@@ src/invariant_mass_histogram.sv @@
// ----------------------------------------------------------------------------
// invariant_mass_histogram: two-body invariant mass histogram
// Squares the summed four-momentum, takes an integer square root, bins the
// mass and keeps saturating 32-bit counts in a 202-slot store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transfer carries either a fill
//   (two four-momenta) or a read of one slot. in_stall is high whenever an
//   item is in progress, so one item is worked on at a time.
//   Result channel (out_valid / out_stall): exactly one result transfer per
//   input transfer, in order. The result sits in an output register, so a
//   new input is taken while the previous result still waits.
//   Sequence: a fill runs through the squarer/accumulator, a sign check, 22
//   square root steps, an underflow compare and 22 restoring divide steps
//   on one shared subtractor, then binning, a count store read and write,
//   and the hand-off to out_valid. A read op or an unphysical / underflow
//   fill skips what it does not need. The next input is taken the cycle
//   after the result moves to the output register.
//   Reset (rst_n low, synchronous): all slot counts read as zero (per-slot
//   valid bits), lower_edge = 0, bin_width = 30.
//   If the receiver stalls, the finished item waits in the last sequencer
//   state until the output register frees; no input is taken meanwhile.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index; only
//   write while the block is idle.
// ----------------------------------------------------------------------------
module invariant_mass_histogram (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_opcode,
  input  logic        [imh_pkg::E_W-1:0]     in_e_first,
  input  logic signed [imh_pkg::P_W-1:0]     in_px_first,
  input  logic signed [imh_pkg::P_W-1:0]     in_py_first,
  input  logic signed [imh_pkg::P_W-1:0]     in_pz_first,
  input  logic        [imh_pkg::E_W-1:0]     in_e_second,
  input  logic signed [imh_pkg::P_W-1:0]     in_px_second,
  input  logic signed [imh_pkg::P_W-1:0]     in_py_second,
  input  logic signed [imh_pkg::P_W-1:0]     in_pz_second,
  input  logic        [imh_pkg::SLOT_W-1:0]  in_slot_index,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [imh_pkg::MASS_W-1:0]  out_mass_mev,
  output logic        [imh_pkg::SLOT_W-1:0]  out_slot_hit,
  output logic                               out_unphysical,
  output logic        [imh_pkg::COUNT_W-1:0] out_slot_count,
  // configuration
  input  logic                               cfg_we,
  input  logic        [imh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [imh_pkg::CFG_W-1:0]   cfg_wdata
);
  import imh_pkg::*;

  // one-hot sequencer
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MUL    = 10'b0000000010,  // squares and accumulate m2
    S_SIGN   = 10'b0000000100,  // check sign of m2
    S_SQRT   = 10'b0000001000,  // one root bit per cycle
    S_DIVPRE = 10'b0000010000,  // mass - lower_edge, underflow check
    S_DIV    = 10'b0000100000,  // one quotient bit per cycle
    S_BIN    = 10'b0001000000,  // quotient to slot number
    S_RD     = 10'b0010000000,  // count store read
    S_WR     = 10'b0100000000,  // bump and write back
    S_DONE   = 10'b1000000000   // hand result to output register
  } state_t;

  localparam int ESUM_W = E_W + 1;      // summed energy
  localparam int PSUM_W = P_W + 1;      // summed momentum, signed
  localparam int OP_W   = PSUM_W;       // squarer operand magnitude
  localparam int SQ_W   = 2 * MASS_W + 1; // a square is at most 2^44
  localparam int ACC_W  = SQ_W + 2;     // signed m2, down to -3*2^44
  localparam int RAD_W  = 2 * MASS_W;   // nonnegative m2 fits here
  localparam int REM_W  = MASS_W + 2;
  localparam int SUB_W  = REM_W + 2;
  localparam int CNT_W  = 5;
  localparam logic [CNT_W-1:0] STEPS_LAST = CNT_W'(MASS_W - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  state_t state_r, state_nxt;

  // configuration registers
  logic [CFG_W-1:0] lower_edge_r;
  logic [CFG_W-1:0] bin_width_r;
  logic [CFG_W-1:0] divisor;

  // item registers
  logic                     opcode_r;
  logic [ESUM_W-1:0]        e_sum_r;
  logic signed [PSUM_W-1:0] px_sum_r, py_sum_r, pz_sum_r;
  logic [SLOT_W-1:0]        slot_r;
  logic                     unphys_r;

  // arithmetic registers
  logic [CNT_W-1:0]  step_r;
  logic [SQ_W-1:0]   prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [MASS_W-1:0] root_r;    // mass; stays 0 on a read or unphysical fill
  logic [MASS_W-1:0] dvd_r;     // dividend in, quotient out

  // count store
  logic [COUNT_W-1:0]    count_mem [SLOT_TOTAL];
  logic [SLOT_TOTAL-1:0] slot_vld_r;
  logic [COUNT_W-1:0]    rd_data_r;
  logic                  rd_vld_r;
  logic                  slot_in_range;
  logic [COUNT_W-1:0]    cur_count;
  logic [COUNT_W-1:0]    bumped_count;
  logic [COUNT_W-1:0]    count_r;

  // output register
  logic                  out_valid_r;
  logic [MASS_W-1:0]     out_mass_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic                  out_unphys_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic in_xfer;
  logic out_free;

  assign in_xfer  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  assign divisor = (bin_width_r == '0) ? CFG_W'(1) : bin_width_r;

  // ---------------------------------------------------------------------------
  // Shared squarer: one square per cycle, registered before accumulation
  // ---------------------------------------------------------------------------
  logic signed [PSUM_W-1:0] p_sel;
  logic [OP_W-1:0]          mul_op;
  logic [2*OP_W-1:0]        mul_full;

  always_comb begin
    p_sel = px_sum_r;
    case (step_r)
      CNT_W'(2): p_sel = py_sum_r;
      CNT_W'(3): p_sel = pz_sum_r;
      default:   p_sel = px_sum_r;
    endcase
  end

  always_comb begin
    if (step_r == '0) begin
      mul_op = OP_W'(e_sum_r);
    end else begin
      mul_op = p_sel[PSUM_W-1] ? OP_W'(-p_sel) : OP_W'(p_sel);
    end
  end

  assign mul_full = mul_op * mul_op;

  // ---------------------------------------------------------------------------
  // Shared subtractor: root trial, underflow compare, divide trial
  // ---------------------------------------------------------------------------
  logic [SUB_W-1:0] sub_a, sub_b;
  logic [SUB_W:0]   sub_diff;
  logic             sub_borrow;

  always_comb begin
    case (state_r)
      S_SQRT: begin
        sub_a = SUB_W'({rem_r, rad_r[RAD_W-1 -: 2]});
        sub_b = SUB_W'({root_r, 2'b01});
      end
      S_DIVPRE: begin
        sub_a = SUB_W'(root_r);
        sub_b = SUB_W'(lower_edge_r);
      end
      S_DIV: begin
        sub_a = SUB_W'({rem_r[MASS_W-1:0], dvd_r[MASS_W-1]});
        sub_b = SUB_W'(divisor);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[SUB_W];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_opcode == OP_READ) ? S_RD : S_MUL;
        end
      end
      S_MUL:    if (step_r == CNT_W'(4)) state_nxt = S_SIGN;
      S_SIGN:   state_nxt = acc_r[ACC_W-1] ? S_RD : S_SQRT;
      S_SQRT:   if (step_r == STEPS_LAST) state_nxt = S_DIVPRE;
      S_DIVPRE: state_nxt = sub_borrow ? S_RD : S_DIV;
      S_DIV:    if (step_r == STEPS_LAST) state_nxt = S_BIN;
      S_BIN:    state_nxt = S_RD;
      S_RD:     state_nxt = S_WR;
      S_WR:     state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_edge_r <= '0;
      bin_width_r  <= BIN_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOWER_EDGE: lower_edge_r <= cfg_wdata;
        CFG_BIN_WIDTH:  bin_width_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          opcode_r <= in_opcode;
          e_sum_r  <= ESUM_W'(in_e_first) + ESUM_W'(in_e_second);
          px_sum_r <= PSUM_W'(in_px_first) + PSUM_W'(in_px_second);
          py_sum_r <= PSUM_W'(in_py_first) + PSUM_W'(in_py_second);
          pz_sum_r <= PSUM_W'(in_pz_first) + PSUM_W'(in_pz_second);
          slot_r   <= (in_opcode == OP_READ) ? in_slot_index : '0;
          unphys_r <= 1'b0;
          root_r   <= '0;
          step_r   <= '0;
        end
      end
      S_MUL: begin
        // square in step k, accumulate it in step k+1
        prod_r <= mul_full[SQ_W-1:0];
        if (step_r == CNT_W'(1)) begin
          acc_r <= ACC_W'(prod_r);
        end else if (step_r != '0) begin
          acc_r <= acc_r - ACC_W'(prod_r);
        end
        step_r <= step_r + 1'b1;
      end
      S_SIGN: begin
        unphys_r <= acc_r[ACC_W-1];
        rad_r    <= acc_r[RAD_W-1:0];
        rem_r    <= '0;
        step_r   <= '0;
      end
      S_SQRT: begin
        // restoring root: bring down two bits, try (root << 2) | 1
        if (!sub_borrow) begin
          rem_r  <= sub_diff[REM_W-1:0];
          root_r <= {root_r[MASS_W-2:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
          root_r <= {root_r[MASS_W-2:0], 1'b0};
        end
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        step_r <= step_r + 1'b1;
      end
      S_DIVPRE: begin
        // borrow means mass below lower_edge: underflow, slot stays 0
        dvd_r  <= sub_diff[MASS_W-1:0];
        rem_r  <= '0;
        step_r <= '0;
      end
      S_DIV: begin
        if (!sub_borrow) begin
          rem_r <= sub_diff[REM_W-1:0];
        end else begin
          rem_r <= REM_W'({rem_r[MASS_W-1:0], dvd_r[MASS_W-1]});
        end
        dvd_r  <= {dvd_r[MASS_W-2:0], !sub_borrow};
        step_r <= step_r + 1'b1;
      end
      S_BIN: begin
        if (dvd_r >= MASS_W'(NUM_BINS)) begin
          slot_r <= SLOT_W'(NUM_BINS + 1);
        end else begin
          slot_r <= SLOT_W'(dvd_r + 1'b1);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Count store: registered read, one write, valid bit per slot
  // ---------------------------------------------------------------------------
  assign slot_in_range = (slot_r < SLOT_W'(SLOT_TOTAL));
  assign cur_count     = rd_vld_r ? rd_data_r : '0;
  assign bumped_count  = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

  always_ff @(posedge clk) begin
    if ((state_r == S_RD) && slot_in_range) begin
      rd_data_r <= count_mem[slot_r];
    end
    if ((state_r == S_WR) && (opcode_r == OP_FILL)) begin
      count_mem[slot_r] <= bumped_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (state_r == S_RD) begin
        rd_vld_r <= slot_in_range && slot_vld_r[slot_r];
      end
      if ((state_r == S_WR) && (opcode_r == OP_FILL)) begin
        slot_vld_r[slot_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WR) begin
      // a read beyond the overflow slot gives 0 (rd_vld_r is low)
      count_r <= (opcode_r == OP_FILL) ? bumped_count : cur_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_mass_r   <= root_r;
      out_slot_r   <= slot_r;
      out_unphys_r <= unphys_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mass_mev   = out_mass_r;
  assign out_slot_hit   = out_slot_r;
  assign out_unphysical = out_unphys_r;
  assign out_slot_count = out_count_r;

endmodule

@@ verif/tb_invariant_mass_histogram.sv @@
// ----------------------------------------------------------------------------
// tb_invariant_mass_histogram: self-checking bench for the mass histogram
// Fills and reads of the histogram are driven through the valid/stall input
// channel. A local model of the squarer, square root, binning and the
// saturating slot store predicts every result, and the results are checked
// field by field, in order. The bin geometry is reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_invariant_mass_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  import imh_pkg::*;

  // run control
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles without any transfer
  localparam int SETTLE_CYCLES   = 120;   // quiet time after the last result

  localparam longint unsigned E_MAX    = (64'd1 << E_W) - 1;
  localparam longint unsigned MASS_TOP = 2 * E_MAX;  // largest reachable mass
  localparam logic signed [P_W-1:0] P_MAX = {1'b0, {(P_W-1){1'b1}}};
  localparam logic signed [P_W-1:0] P_MIN = {1'b1, {(P_W-1){1'b0}}};

  // one input transfer: a fill (two four-momenta) or a slot read
  typedef struct {
    logic                    opcode;
    logic        [E_W-1:0]   e_first;
    logic signed [P_W-1:0]   px_first;
    logic signed [P_W-1:0]   py_first;
    logic signed [P_W-1:0]   pz_first;
    logic        [E_W-1:0]   e_second;
    logic signed [P_W-1:0]   px_second;
    logic signed [P_W-1:0]   py_second;
    logic signed [P_W-1:0]   pz_second;
    logic        [SLOT_W-1:0] slot_index;
  } pair_item_t;

  // one result transfer
  typedef struct {
    logic [MASS_W-1:0]  mass_mev;
    logic [SLOT_W-1:0]  slot_hit;
    logic               unphysical;
    logic [COUNT_W-1:0] slot_count;
  } hist_result_t;

  // --------------------------------------------------------------------------
  // DUT ports, all at known values from time zero
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_opcode = OP_FILL;
  logic        [E_W-1:0]   in_e_first = '0;
  logic signed [P_W-1:0]   in_px_first = '0;
  logic signed [P_W-1:0]   in_py_first = '0;
  logic signed [P_W-1:0]   in_pz_first = '0;
  logic        [E_W-1:0]   in_e_second = '0;
  logic signed [P_W-1:0]   in_px_second = '0;
  logic signed [P_W-1:0]   in_py_second = '0;
  logic signed [P_W-1:0]   in_pz_second = '0;
  logic        [SLOT_W-1:0] in_slot_index = '0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [MASS_W-1:0]       out_mass_mev;
  logic [SLOT_W-1:0]       out_slot_hit;
  logic                    out_unphysical;
  logic [COUNT_W-1:0]      out_slot_count;

  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_LOWER_EDGE;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  invariant_mass_histogram dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_e_first    (in_e_first),
    .in_px_first   (in_px_first),
    .in_py_first   (in_py_first),
    .in_pz_first   (in_pz_first),
    .in_e_second   (in_e_second),
    .in_px_second  (in_px_second),
    .in_py_second  (in_py_second),
    .in_pz_second  (in_pz_second),
    .in_slot_index (in_slot_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mass_mev  (out_mass_mev),
    .out_slot_hit  (out_slot_hit),
    .out_unphysical(out_unphysical),
    .out_slot_count(out_slot_count),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  pair_item_t   pair_backlog[$];     // items waiting to be offered
  hist_result_t expected_hits[$];    // predicted results, oldest first
  pair_item_t   on_bus;              // item currently offered on the input

  // shadow of the histogram and its geometry
  logic [COUNT_W-1:0] slot_tally[SLOT_TOTAL] = '{default: '0};
  logic [CFG_W-1:0]   lower_edge_mev = '0;
  logic [CFG_W-1:0]   bin_width_mev  = BIN_WIDTH_RST;

  int in_issued = 0;      // items put on the input bus
  int in_xfers = 0;       // input transfers seen
  int errors = 0;
  int idle_cycles = 0;    // watchdog: cycles with no transfer on either side

  int hold_off_asks = 0;  // bumped by the sequence to request a long hold-off
  int hold_off_done = 0;
  bit tail_quiet = 1'b0;  // final phase: no idling on either side

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // digit-by-digit integer root; radicand stays below 2^47
  function automatic longint unsigned floor_sqrt(longint unsigned radicand);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 23; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root;
  endfunction

  // applies one accepted item to the shadow histogram, returns its result
  function automatic hist_result_t histogram_step(pair_item_t it);
    hist_result_t    res;
    longint          e_sum, px_sum, py_sum, pz_sum, m2;
    longint unsigned mass, width, quot;
    int              slot;
    res = '{default: '0};
    if (it.opcode == OP_READ) begin
      // reads past the overflow slot return zero and echo the index
      res.slot_hit   = it.slot_index;
      res.slot_count = (it.slot_index < SLOT_TOTAL) ? slot_tally[it.slot_index] : '0;
    end else begin
      e_sum  = longint'(it.e_first) + longint'(it.e_second);
      px_sum = longint'(it.px_first) + longint'(it.px_second);
      py_sum = longint'(it.py_first) + longint'(it.py_second);
      pz_sum = longint'(it.pz_first) + longint'(it.pz_second);
      m2 = e_sum * e_sum - (px_sum * px_sum + py_sum * py_sum + pz_sum * pz_sum);
      if (m2 < 0) begin
        // spacelike pair: flagged, mass reads zero, lands in underflow
        res.unphysical = 1'b1;
        slot = 0;
      end else begin
        mass = floor_sqrt($unsigned(m2));
        res.mass_mev = mass[MASS_W-1:0];
        width = (bin_width_mev == 0) ? 64'd1 : 64'(bin_width_mev);
        if (mass < lower_edge_mev) begin
          slot = 0;
        end else begin
          quot = (mass - lower_edge_mev) / width;
          slot = (quot >= NUM_BINS) ? NUM_BINS + 1 : int'(quot) + 1;
        end
      end
      if (slot_tally[slot] != '1) slot_tally[slot] = slot_tally[slot] + 1'b1;
      res.slot_hit   = slot[SLOT_W-1:0];
      res.slot_count = slot_tally[slot];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------

  // every field random over its full width
  function automatic pair_item_t noise_item();
    pair_item_t it;
    it.opcode     = 1'($urandom_range(1, 0));
    it.e_first    = E_W'($urandom);
    it.px_first   = P_W'($urandom);
    it.py_first   = P_W'($urandom);
    it.pz_first   = P_W'($urandom);
    it.e_second   = E_W'($urandom);
    it.px_second  = P_W'($urandom);
    it.py_second  = P_W'($urandom);
    it.pz_second  = P_W'($urandom);
    it.slot_index = SLOT_W'($urandom);
    return it;
  endfunction

  // read; the momentum payload is don't-care and stays random
  function automatic pair_item_t read_slot(int unsigned idx);
    pair_item_t it;
    it = noise_item();
    it.opcode = OP_READ;
    it.slot_index = SLOT_W'(idx);
    return it;
  endfunction

  // both particles get energy e and every momentum component p
  function automatic pair_item_t edge_fill(logic [E_W-1:0] e, logic signed [P_W-1:0] p);
    pair_item_t it;
    it = noise_item();
    it.opcode = OP_FILL;
    it.e_first = e;
    it.e_second = e;
    {it.px_first, it.py_first, it.pz_first} = {p, p, p};
    {it.px_second, it.py_second, it.pz_second} = {p, p, p};
    return it;
  endfunction

  // uniform in [-2^reach, 2^reach)
  function automatic logic signed [P_W-1:0] momentum_draw(int unsigned reach);
    int span;
    span = 1 << reach;
    return P_W'($signed($urandom_range(2 * span - 1, 0)) - span);
  endfunction

  // fill whose mass sits at (moving = 0) or just under (moving = 1) the target
  function automatic pair_item_t fill_at_mass(longint unsigned mass, bit moving);
    pair_item_t      it;
    longint unsigned target, mom_sq, e_total, e_lo, e_hi;
    longint          sx, sy, sz;
    int unsigned     reach;
    it = noise_item();
    it.opcode = OP_FILL;
    target = (mass > MASS_TOP) ? MASS_TOP : mass;
    if (moving) begin
      // mostly modest momenta, some near the top of the field
      reach = ($urandom_range(3, 0) == 0) ? $urandom_range(20, 11) : $urandom_range(10, 0);
      it.px_first  = momentum_draw(reach);
      it.py_first  = momentum_draw(reach);
      it.pz_first  = momentum_draw(reach);
      it.px_second = momentum_draw(reach);
      it.py_second = momentum_draw(reach);
      it.pz_second = momentum_draw(reach);
    end else begin
      {it.px_first, it.py_first, it.pz_first} = '0;
      {it.px_second, it.py_second, it.pz_second} = '0;
    end
    sx = longint'(it.px_first) + longint'(it.px_second);
    sy = longint'(it.py_first) + longint'(it.py_second);
    sz = longint'(it.pz_first) + longint'(it.pz_second);
    mom_sq  = $unsigned(sx * sx + sy * sy + sz * sz);
    e_total = floor_sqrt(target * target + mom_sq);
    if (e_total > MASS_TOP) begin
      // boost too large for the energy fields: fall back to a pair at rest
      {it.px_first, it.py_first, it.pz_first} = '0;
      {it.px_second, it.py_second, it.pz_second} = '0;
      e_total = target;
    end
    e_lo = (e_total > E_MAX) ? e_total - E_MAX : 64'd0;
    e_hi = (e_total < E_MAX) ? e_total : E_MAX;
    it.e_first  = E_W'($urandom_range(32'(e_hi), 32'(e_lo)));
    it.e_second = E_W'(e_total - it.e_first);
    return it;
  endfunction

  // fill aimed at a given slot under the current bin geometry
  function automatic pair_item_t aimed_fill(int unsigned slot);
    longint unsigned width, mass;
    width = (bin_width_mev == 0) ? 64'd1 : 64'(bin_width_mev);
    if (slot == 0)
      mass = (lower_edge_mev == 0) ? 64'd0
                                   : 64'($urandom_range(32'(lower_edge_mev) - 1, 0));
    else if (slot > NUM_BINS)
      mass = lower_edge_mev + width * NUM_BINS + 64'($urandom_range(5000, 0));
    else
      mass = lower_edge_mev + width * (slot - 1) + 64'($urandom_range(32'(width - 1), 0));
    return fill_at_mass(mass, $urandom_range(2, 0) != 0);
  endfunction

  // mix: aimed fills with edge slots favored, reads, and raw noise
  // (raw noise is mostly spacelike and feeds the underflow slot)
  task automatic queue_random(int n);
    int unsigned pick;
    int unsigned target;
    repeat (n) begin
      pick = $urandom_range(99, 0);
      if (pick < 60) begin
        case ($urandom_range(3, 0))
          0: begin
            case ($urandom_range(3, 0))
              0: target = 0;
              1: target = 1;
              2: target = NUM_BINS;
              default: target = NUM_BINS + 1;
            endcase
          end
          default: target = $urandom_range(NUM_BINS + 1, 0);
        endcase
        pair_backlog.push_back(aimed_fill(target));
      end else if (pick < 75) begin
        target = ($urandom_range(9, 0) == 0) ? $urandom_range(255, SLOT_TOTAL)
                                             : $urandom_range(SLOT_TOTAL - 1, 0);
        pair_backlog.push_back(read_slot(target));
      end else begin
        pair_backlog.push_back(noise_item());
      end
    end
  endtask

  // sender holds until every offered item is taken and every result is back
  task automatic drain_all();
    while (pair_backlog.size() != 0 || in_xfers != in_issued || expected_hits.size() != 0)
      @(negedge clk);
  endtask

  // reprogram the bin geometry; only done with the block idle
  task automatic set_bins(logic [CFG_W-1:0] lower, logic [CFG_W-1:0] width);
    drain_all();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOWER_EDGE;
    cfg_wdata <= lower;
    @(negedge clk);
    cfg_index <= CFG_BIN_WIDTH;
    cfg_wdata <= width;
    @(negedge clk);
    cfg_we <= 1'b0;
    lower_edge_mev = lower;
    bin_width_mev  = width;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: changes on the falling edge. The offered item is held
  // until its transfer has been seen at a rising edge, then replaced, or the
  // bus goes idle for a random burst.
  // --------------------------------------------------------------------------
  int send_gap = 0;   // idle cycles left in the current burst
  int send_calm = 0;  // cycles left in a stretch with no idling

  always @(negedge clk) begin
    bit bus_free;
    bus_free = !in_valid || (in_xfers == in_issued);
    if (rst_n && bus_free) begin
      if (send_calm != 0) send_calm--;
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!tail_quiet && send_calm == 0 && $urandom_range(5, 0) == 0) begin
        send_gap = $urandom_range(7, 0);
        if ($urandom_range(3, 0) == 0) send_calm = $urandom_range(150, 20);
        in_valid <= 1'b0;
      end else if (pair_backlog.size() != 0) begin
        on_bus = pair_backlog.pop_front();
        in_opcode     <= on_bus.opcode;
        in_e_first    <= on_bus.e_first;
        in_px_first   <= on_bus.px_first;
        in_py_first   <= on_bus.py_first;
        in_pz_first   <= on_bus.pz_first;
        in_e_second   <= on_bus.e_second;
        in_px_second  <= on_bus.px_second;
        in_py_second  <= on_bus.py_second;
        in_pz_second  <= on_bus.pz_second;
        in_slot_index <= on_bus.slot_index;
        in_valid      <= 1'b1;
        in_issued++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result stall: random bursts, calm stretches, and on request one long
  // hold-off so the output register and the input side back up.
  // --------------------------------------------------------------------------
  int hold_left = 0;
  int stall_left = 0;
  int stall_calm = 0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      if (hold_left == 0) hold_off_done++;
      out_stall <= 1'b1;
    end else if (hold_off_done != hold_off_asks) begin
      hold_left = HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (tail_quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_calm != 0) begin
      stall_calm--;
      out_stall <= 1'b0;
    end else if ($urandom_range(5, 0) == 0) begin
      stall_left = $urandom_range(7, 0);
      if ($urandom_range(3, 0) == 0) stall_calm = $urandom_range(150, 20);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: rising-edge sampling of both channels. An input transfer is
  // predicted right away; a result transfer is checked against the oldest
  // prediction. Also runs the no-progress watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit           moved;
    hist_result_t want;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      expected_hits.push_back(histogram_step(on_bus));
      in_xfers++;
      moved = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (expected_hits.size() == 0) begin
        $error("result with nothing pending: slot_hit %0d slot_count %0d",
               out_slot_hit, out_slot_count);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        if (out_mass_mev !== want.mass_mev) begin
          $error("mass_mev: expected %0d, actual %0d", want.mass_mev, out_mass_mev);
          errors++;
        end
        if (out_slot_hit !== want.slot_hit) begin
          $error("slot_hit: expected %0d, actual %0d", want.slot_hit, out_slot_hit);
          errors++;
        end
        if (out_unphysical !== want.unphysical) begin
          $error("unphysical: expected %0d, actual %0d", want.unphysical, out_unphysical);
          errors++;
        end
        if (out_slot_count !== want.slot_count) begin
          $error("slot_count: expected %0d, actual %0d", want.slot_count, out_slot_count);
          errors++;
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry (edge 0, width 30): directed corners first
    pair_backlog.push_back(edge_fill('0, '0));          // zero mass, first bin
    pair_backlog.push_back(read_slot(1));
    pair_backlog.push_back(fill_at_mass(29, 1'b0));     // top of first bin
    pair_backlog.push_back(fill_at_mass(30, 1'b0));     // bottom of second bin
    pair_backlog.push_back(fill_at_mass(5999, 1'b0));   // last bin
    pair_backlog.push_back(fill_at_mass(6000, 1'b0));   // first overflow mass
    pair_backlog.push_back(edge_fill(E_W'(E_MAX), '0)); // heaviest pair at rest
    pair_backlog.push_back(edge_fill(E_W'(E_MAX), '1)); // just under the top
    pair_backlog.push_back(edge_fill(E_W'(E_MAX), P_MAX)); // spacelike, max momenta
    pair_backlog.push_back(edge_fill(E_W'(E_MAX), P_MIN)); // spacelike, min momenta
    pair_backlog.push_back(edge_fill('0, P_MAX));       // no energy at all
    pair_backlog.push_back(read_slot(0));
    pair_backlog.push_back(read_slot(NUM_BINS));
    pair_backlog.push_back(read_slot(NUM_BINS + 1));
    pair_backlog.push_back(read_slot(SLOT_TOTAL));      // past the store
    pair_backlog.push_back(read_slot(255));
    queue_random(60);

    // unit bins; the receiver holds off long enough to back up the input
    set_bins('0, 22'd1);
    hold_off_asks++;
    queue_random(45);

    // offset histogram: masses just below and at the lower edge
    set_bins(22'd1000, 22'd30);
    pair_backlog.push_back(fill_at_mass(999, 1'b0));
    pair_backlog.push_back(fill_at_mass(1000, 1'b0));
    queue_random(45);

    // both registers at full scale: everything underflows
    set_bins('1, '1);
    queue_random(40);

    // zero width behaves as width one
    set_bins('0, '0);
    pair_backlog.push_back(fill_at_mass(199, 1'b0));
    pair_backlog.push_back(fill_at_mass(200, 1'b0));
    queue_random(45);

    // one huge bin
    set_bins('0, '1);
    queue_random(35);

    set_bins(CFG_W'($urandom_range(200000, 0)), CFG_W'($urandom_range(2000, 1)));
    queue_random(45);

    // last stretch at full rate, no idling on either side
    set_bins(22'd500, 22'd7);
    tail_quiet = 1'b1;
    queue_random(40);

    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
